// ===== hdl/bounded_keyed_stack_defines.svh =====
// Assertion macros shared by the bounded keyed stack RTL.
// Depends on nothing; the asserting module must have clk and rst_n in scope.
`ifndef BOUNDED_KEYED_STACK_DEFINES_SVH
`define BOUNDED_KEYED_STACK_DEFINES_SVH

`ifndef SYNTH

// The condition holds at every clock edge out of reset.
`define BKS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent holds at the same edge.
`define BKS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent holds at the next edge.
`define BKS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BKS_ASSERT_ALWAYS(lbl, cond, msg)
`define BKS_ASSERT_SAME(lbl, ante, cons, msg)
`define BKS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== hdl/bks_pkg.sv =====
// Package for the bounded keyed stack: sizes, command codes and shared types.
// Depends on nothing; bks_if, bks_cell and the top level import it.
package bks_pkg;

    localparam int DEPTH        = 128;
    localparam int PAYLOAD_BITS = 32;

    localparam int KEY_W       = 32;
    localparam int DATA_W      = 32;
    localparam int COUNT_OUT_W = 8;
    localparam int CMD_W       = 2;

    // Only the low bits of the payload port that fit the stored width are kept.
    localparam int STORE_BITS = (PAYLOAD_BITS < DATA_W) ? PAYLOAD_BITS : DATA_W;
    // Entry count ranges over 0..DEPTH inclusive.
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_EXISTS = 2'd2
    } cmd_t;

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } state_t;

    // Shift command broadcast to every cell of the chain.
    typedef struct packed {
        logic push;
        logic pop;
    } shift_ctl_t;

endpackage

// ===== hdl/bks_if.sv =====
// Valid/ready channel interfaces for the bounded keyed stack.
// Depends on bks_pkg for field widths.
interface bks_in_if import bks_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        command;
    logic signed [KEY_W-1:0] key;
    logic [DATA_W-1:0]       payload;

    modport source (output valid, command, key, payload, input ready);
    modport sink   (input valid, command, key, payload, output ready);
endinterface

interface bks_out_if import bks_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    ok;
    logic                    found;
    logic signed [KEY_W-1:0] key_out;
    logic [DATA_W-1:0]       payload_out;
    logic [COUNT_OUT_W-1:0]  count;

    modport source (output valid, ok, found, key_out, payload_out, count, input ready);
    modport sink   (input valid, ok, found, key_out, payload_out, count, output ready);
endinterface

// ===== hdl/bks_cell.sv =====
// One cell of the stack chain: holds one entry and one stage of the key search.
// Depends on bks_pkg.
module bks_cell import bks_pkg::*;
(
    input  logic                    clk,
    input  shift_ctl_t              ctl,
    input  logic                    live,
    input  logic signed [KEY_W-1:0] up_key,
    input  logic [STORE_BITS-1:0]   up_payload,
    input  logic signed [KEY_W-1:0] down_key,
    input  logic [STORE_BITS-1:0]   down_payload,
    input  logic signed [KEY_W-1:0] query_key,
    input  logic                    hit_in,
    output logic signed [KEY_W-1:0] key,
    output logic [STORE_BITS-1:0]   payload,
    output logic                    hit
);

    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [STORE_BITS-1:0]   payload_reg, payload_next;
    logic                    hit_reg, hit_next;

    always_comb
    begin
        key_next     = key_reg;
        payload_next = payload_reg;
        if (ctl.push)
        begin
            key_next     = up_key;
            payload_next = up_payload;
        end
        else if (ctl.pop)
        begin
            key_next     = down_key;
            payload_next = down_payload;
        end
        // The search result ripples one cell further on each clock.
        hit_next = hit_in | (live & (key_reg == query_key));
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
        hit_reg     <= hit_next;
    end

    assign key     = key_reg;
    assign payload = payload_reg;
    assign hit     = hit_reg;

endmodule

// ===== hdl/bounded_keyed_stack.sv =====
// Top level of the bounded keyed stack: control, entry count and result register.
// Depends on bks_pkg, bks_if, bks_cell and bounded_keyed_stack_defines.svh.
//
// Usage: items arrive on the req channel (command, key, payload) and each one
// yields exactly one transaction on the rsp channel (ok, found, key_out,
// payload_out, count). Both channels use valid/ready; a transaction completes
// on a clock edge where both are high.
// The entries live in a chain of DEPTH cells with the top of the stack in
// cell 0. A successful push shifts every entry one cell down and a successful
// pop one cell up, all cells at once, so push, pop and the unused command give
// a valid result in the cycle after acceptance and may follow one another
// every cycle while the receiver takes each result.
// An exists query compares every live cell against the registered query key
// and ripples the match flag down the chain one cell per clock; its result is
// taken from the last cell, and req.ready stays low while it runs.
// The result sits in an output register. A new item is accepted while the
// previous result is being taken in the same cycle; if the receiver stalls,
// the result holds and req.ready drops until it is taken.
// Reset (rst_n low, asynchronous) empties the stack, clears the pending
// result and returns the control to idle; stored entries are not cleared.
`include "bounded_keyed_stack_defines.svh"

module bounded_keyed_stack import bks_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    bks_in_if.sink    req,
    bks_out_if.source rsp
);

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        top_reg, top_next;
    logic [CNT_W-1:0]        search_cnt_reg, search_cnt_next;
    logic signed [KEY_W-1:0] query_key_reg;

    logic                    rsp_valid_reg, rsp_valid_next;
    logic                    rsp_ok_reg;
    logic                    rsp_found_reg;
    logic signed [KEY_W-1:0] rsp_key_reg;
    logic [DATA_W-1:0]       rsp_payload_reg;
    logic [COUNT_OUT_W-1:0]  rsp_count_reg;

    logic                    in_ready;
    logic                    accept;
    logic                    out_free;
    logic                    load;
    logic                    r_ok;
    logic                    r_found;
    logic signed [KEY_W-1:0] r_key;
    logic [DATA_W-1:0]       r_payload;
    shift_ctl_t              shift;

    logic signed [KEY_W-1:0] cell_key     [DEPTH];
    logic [STORE_BITS-1:0]   cell_payload [DEPTH];
    logic                    cell_hit     [DEPTH];

    // The chain of cells. Cell 0 is the top of the stack; it takes a pushed
    // entry from the input port, and the last cell takes zeros on a pop.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [KEY_W-1:0] up_key;
        logic [STORE_BITS-1:0]   up_payload;
        logic signed [KEY_W-1:0] down_key;
        logic [STORE_BITS-1:0]   down_payload;
        logic                    hit_in;
        logic                    live;

        if (i == 0)
        begin : g_first
            assign up_key     = req.key;
            assign up_payload = req.payload[STORE_BITS-1:0];
            assign hit_in     = 1'b0;
        end
        else
        begin : g_inner
            assign up_key     = cell_key[i-1];
            assign up_payload = cell_payload[i-1];
            assign hit_in     = cell_hit[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign down_key     = '0;
            assign down_payload = '0;
        end
        else
        begin : g_lower
            assign down_key     = cell_key[i+1];
            assign down_payload = cell_payload[i+1];
        end

        // A cell holds an entry when its position is below the entry count.
        assign live = (top_reg > CNT_W'(i));

        bks_cell u_cell (
            .clk          (clk),
            .ctl          (shift),
            .live         (live),
            .up_key       (up_key),
            .up_payload   (up_payload),
            .down_key     (down_key),
            .down_payload (down_payload),
            .query_key    (query_key_reg),
            .hit_in       (hit_in),
            .key          (cell_key[i]),
            .payload      (cell_payload[i]),
            .hit          (cell_hit[i])
        );
    end

    // Next state, stack control and the result to be registered.
    always_comb
    begin
        out_free        = !rsp_valid_reg || rsp.ready;
        in_ready        = (state_reg == S_IDLE) && out_free;
        accept          = req.valid && in_ready;
        state_next      = state_reg;
        top_next        = top_reg;
        search_cnt_next = search_cnt_reg;
        shift           = '0;
        load            = 1'b0;
        r_ok            = 1'b0;
        r_found         = 1'b0;
        r_key           = '0;
        r_payload       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd_t'(req.command))
                        CMD_PUSH:
                        begin
                            load = 1'b1;
                            if (top_reg != CNT_W'(DEPTH))
                            begin
                                shift.push = 1'b1;
                                top_next   = top_reg + CNT_W'(1);
                                r_ok       = 1'b1;
                            end
                        end
                        CMD_POP:
                        begin
                            load = 1'b1;
                            if (top_reg != '0)
                            begin
                                shift.pop = 1'b1;
                                top_next  = top_reg - CNT_W'(1);
                                r_ok      = 1'b1;
                                r_key     = cell_key[0];
                                r_payload = DATA_W'(cell_payload[0]);
                            end
                        end
                        CMD_EXISTS:
                        begin
                            state_next      = S_SEARCH;
                            search_cnt_next = '0;
                        end
                        default:
                        begin
                            // The unused command code reports failure and
                            // leaves the stack alone.
                            load = 1'b1;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                // Once the search counter reaches DEPTH the last cell carries the verdict for
                // the whole chain; it then holds until the result is taken.
                if (search_cnt_reg != CNT_W'(DEPTH))
                begin
                    search_cnt_next = search_cnt_reg + CNT_W'(1);
                end
                else if (out_free)
                begin
                    load       = 1'b1;
                    r_ok       = 1'b1;
                    r_found    = cell_hit[DEPTH-1];
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            top_reg        <= '0;
            search_cnt_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            top_reg        <= top_next;
            search_cnt_reg <= search_cnt_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Result and query registers carry data only and need no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            query_key_reg <= req.key;
        end
        if (load)
        begin
            rsp_ok_reg      <= r_ok;
            rsp_found_reg   <= r_found;
            rsp_key_reg     <= r_key;
            rsp_payload_reg <= r_payload;
            rsp_count_reg   <= COUNT_OUT_W'(top_next);
        end
    end

    assign req.ready       = in_ready;
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.ok          = rsp_ok_reg;
    assign rsp.found       = rsp_found_reg;
    assign rsp.key_out     = rsp_key_reg;
    assign rsp.payload_out = rsp_payload_reg;
    assign rsp.count       = rsp_count_reg;

    `BKS_ASSERT_ALWAYS(a_count_bound, top_reg <= CNT_W'(DEPTH), "entry count exceeds depth")
    `BKS_ASSERT_SAME(a_no_accept_in_search, state_reg == S_SEARCH, !req.ready, "input taken during a search")
    `BKS_ASSERT_NEXT(a_push_grows, accept && req.command == CMD_PUSH && top_reg != CNT_W'(DEPTH), top_reg == $past(top_reg) + CNT_W'(1), "successful push did not grow the stack")
    `BKS_ASSERT_NEXT(a_pop_result, accept && req.command == CMD_POP && top_reg != '0, rsp.valid && rsp.ok, "successful pop gave no ok result")
    `BKS_ASSERT_SAME(a_search_holds_stack, state_reg == S_SEARCH, !shift.push && !shift.pop, "stack shifted during a search")

endmodule
